// ----- rtl/core/assert_macros.svh -----
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ALC_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
`define ALC_ASSERT_RST(label, clk, prop) \
   label: assert property (@(posedge clk) (prop)) \
      else $error("assertion failed");
`else
`define ALC_ASSERT(label, clk, rst, prop)
`define ALC_ASSERT_RST(label, clk, prop)
`endif

`endif

// ----- rtl/core/alc_pkg.sv -----
package alc_pkg;

   localparam int DATA_W  = 32;
   localparam int OP_W    = 3;
   localparam int POS_W   = 6;
   localparam int COUNT_W = 6;

   localparam logic [OP_W-1:0] OP_APPEND     = 3'd0;
   localparam logic [OP_W-1:0] OP_REMOVE     = 3'd1;
   localparam logic [OP_W-1:0] OP_REMOVE_ODD = 3'd2;
   localparam logic [OP_W-1:0] OP_READ       = 3'd3;
   localparam logic [OP_W-1:0] OP_MIN        = 3'd4;

   typedef struct packed {
      logic walk;
      logic keep;
      logic app_en;
   } cell_ctrl_type;

endpackage

// ----- rtl/core/array_list_engine_core.sv -----
// array_list_engine_core: ordered list of signed 32-bit values in a ring of cells
// req channel: op, value, position; one beat per command, valid/ready.
// rsp channel: ok, data_out, count, empty_res; exactly one beat per command.
// append, and any command refused up front (empty list, bad position, bad op),
// goes from accept through the result state and the output register to its beat.
// remove value, remove odd, read and minimum rotate the whole ring of
// CAPACITY cells once through cell 0, dropping entries as they pass, then
// go through the result state and the output register to the result beat.
// one command is in work at a time; req_ready is high while no command is
// in work, so a command may be accepted while the last result beat waits.
// if the receiver stalls, the result beat holds and a finished command waits
// for the output register before the next command is taken.
// reset (synchronous, active high) empties the list and drops any beat held;
// the cell contents are not cleared, entries beyond the count are never read.
`include "assert_macros.svh"

module array_list_engine_core #(
   parameter int CAPACITY = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [alc_pkg::OP_W-1:0]             req_op,
   input  logic signed [alc_pkg::DATA_W-1:0]    req_value,
   input  logic [alc_pkg::POS_W-1:0]            req_position,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_ok,
   output logic signed [alc_pkg::DATA_W-1:0]    rsp_data_out,
   output logic [alc_pkg::COUNT_W-1:0]          rsp_count,
   output logic                                 rsp_empty_res
);
   import alc_pkg::*;

   localparam int CW    = $clog2(CAPACITY + 1);
   localparam int JW    = $clog2(CAPACITY);
   localparam int CMP_W = ((CW > POS_W) ? CW : POS_W) + 1;
   localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);
   localparam logic [JW-1:0] LAST_J = JW'(CAPACITY - 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_WALK = 2'd1;
   localparam logic [1:0] ST_RESP = 2'd2;

   logic [1:0]               state_ff, state_in;
   logic [JW-1:0]            step_ff, step_in;
   logic [CW-1:0]            count_ff, count_in;
   logic [CW-1:0]            len_ff, len_in;
   logic                     found_ff, found_in;
   logic                     ok_ff, ok_in;
   logic [OP_W-1:0]          op_ff, op_in;
   logic signed [DATA_W-1:0] value_ff, value_in;
   logic [POS_W-1:0]         pos_ff, pos_in;
   logic signed [DATA_W-1:0] data_ff, data_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_ok_ff, rsp_ok_in;
   logic signed [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [COUNT_W-1:0]       rsp_count_ff, rsp_count_in;
   logic                     rsp_empty_ff, rsp_empty_in;

   logic signed [DATA_W-1:0] cell_q [CAPACITY];
   logic signed [DATA_W-1:0] head;
   cell_ctrl_type            cell_ctrl;
   logic                     req_fire;
   logic                     in_list;
   logic                     hit;
   logic                     keep;
   logic                     last_step;
   logic                     rsp_free;
   logic                     not_full;

   assign head      = cell_q[0];
   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign not_full  = (count_ff < CAP_C);
   assign in_list   = (CW'(step_ff) < count_ff);
   assign hit       = (op_ff == OP_REMOVE) && in_list && !found_ff && (head == value_ff);
   assign keep      = in_list && !hit && !((op_ff == OP_REMOVE_ODD) && head[0]);
   assign last_step = (step_ff == LAST_J);
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   assign cell_ctrl.walk   = (state_ff == ST_WALK);
   assign cell_ctrl.keep   = keep;
   assign cell_ctrl.app_en = req_fire && (req_op == OP_APPEND) && not_full;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [DATA_W-1:0] up;
      if (i == CAPACITY - 1) begin : g_last
         assign up = head;
      end else begin : g_mid
         assign up = cell_q[i + 1];
      end
      alc_cell #(
         .CW    (CW),
         .INDEX (i)
      ) u_cell (
         .clock    (clock),
         .ctrl     (cell_ctrl),
         .len      (len_ff),
         .app_idx  (count_ff),
         .up_data  (up),
         .head     (head),
         .app_data (req_value),
         .q        (cell_q[i])
      );
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      count_in = count_ff;
      len_in   = len_ff;
      found_in = found_ff;
      ok_in    = ok_ff;
      op_in    = op_ff;
      value_in = value_ff;
      pos_in   = pos_ff;
      data_in  = data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               op_in    = req_op;
               value_in = req_value;
               pos_in   = req_position;
               step_in  = '0;
               len_in   = CAP_C;
               found_in = 1'b0;
               data_in  = '0;
               ok_in    = 1'b0;
               state_in = ST_RESP;
               case (req_op)
                  OP_APPEND: begin
                     ok_in = not_full;
                     if (not_full) begin
                        count_in = count_ff + 1'b1;
                     end
                  end
                  OP_REMOVE, OP_REMOVE_ODD, OP_MIN: begin
                     if (count_ff != '0) begin
                        state_in = ST_WALK;
                     end
                  end
                  OP_READ: begin
                     if (count_ff != '0 && req_position != '0 &&
                         CMP_W'(req_position) <= CMP_W'(count_ff)) begin
                        state_in = ST_WALK;
                     end
                  end
                  default: begin
                     state_in = ST_RESP;
                  end
               endcase
            end
         end
         ST_WALK: begin
            step_in  = step_ff + 1'b1;
            found_in = found_ff || hit;
            if (!keep) begin
               len_in = len_ff - 1'b1;
            end
            if (op_ff == OP_MIN && in_list && (step_ff == '0 || head < data_ff)) begin
               data_in = head;
            end
            if (op_ff == OP_READ && CMP_W'(step_ff) + 1'b1 == CMP_W'(pos_ff)) begin
               data_in = head;
            end
            if (last_step) begin
               count_in = len_in;
               ok_in    = (op_ff != OP_REMOVE) || found_ff || hit;
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_count_in = rsp_count_ff;
      rsp_empty_in = rsp_empty_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (state_ff == ST_RESP && rsp_free) begin
         rsp_valid_in = 1'b1;
         rsp_ok_in    = ok_ff;
         rsp_data_in  = data_ff;
         rsp_count_in = COUNT_W'(count_ff);
         rsp_empty_in = (count_ff == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         count_ff     <= '0;
         len_ff       <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         count_ff     <= count_in;
         len_ff       <= len_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ok_ff        <= ok_in;
      op_ff        <= op_in;
      value_ff     <= value_in;
      pos_ff       <= pos_in;
      data_ff      <= data_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_count_ff <= rsp_count_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_ok        = rsp_ok_ff;
   assign rsp_data_out  = rsp_data_ff;
   assign rsp_count     = rsp_count_ff;
   assign rsp_empty_res = rsp_empty_ff;

   `ALC_ASSERT_RST(a_count_bound, clock, reset || count_ff <= CAP_C)
   `ALC_ASSERT(a_walk_ends, clock, reset,
      (state_ff == ST_WALK && last_step) |=> (state_ff == ST_RESP))
   `ALC_ASSERT(a_walk_no_growth, clock, reset,
      (state_ff == ST_WALK && last_step) |=> (count_ff <= $past(count_ff)))
   `ALC_ASSERT(a_ring_len, clock, reset,
      (state_ff == ST_WALK) |-> (len_ff + CW'(CAPACITY - 1) - CW'(step_ff) >= CAP_C - 1'b1 ||
      len_ff <= CAP_C))

endmodule

// ----- rtl/core/alc_cell.sv -----
module alc_cell #(
   parameter int CW    = 6,
   parameter int INDEX = 0
) (
   input  logic                                 clock,
   input  alc_pkg::cell_ctrl_type               ctrl,
   input  logic [CW-1:0]                        len,
   input  logic [CW-1:0]                        app_idx,
   input  logic signed [alc_pkg::DATA_W-1:0]    up_data,
   input  logic signed [alc_pkg::DATA_W-1:0]    head,
   input  logic signed [alc_pkg::DATA_W-1:0]    app_data,
   output logic signed [alc_pkg::DATA_W-1:0]    q
);
   import alc_pkg::*;

   localparam logic [CW-1:0] MY_IDX  = CW'(INDEX);
   localparam logic [CW-1:0] MY_TAIL = CW'(INDEX + 1);

   logic signed [DATA_W-1:0] q_ff;
   logic signed [DATA_W-1:0] q_in;

   always_comb begin
      q_in = q_ff;
      if (ctrl.app_en && app_idx == MY_IDX) begin
         q_in = app_data;
      end else if (ctrl.walk) begin
         // tail of the shrinking ring takes the recirculated head
         if (ctrl.keep && len == MY_TAIL) begin
            q_in = head;
         end else begin
            q_in = up_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

   assign q = q_ff;

endmodule
